// File: rtl/civdg_pkg.sv
// Shared types, constants and calendar tables for the civil date day gap block.
// No dependencies; imported by civdg_date and civil_date_day_gap_top.
package civdg_pkg;

  localparam int YEAR_W   = 14;
  localparam int MD_W     = 7;
  localparam int GAP_W    = 22;
  localparam int STATUS_W = 2;

  localparam logic [YEAR_W-1:0] YEAR_MAX   = 14'd9999;
  localparam logic [14:0]       YEAR_SHIFT = 15'd400;

  // floor(y / 100) = (y * RECIP_100) >> Q100_SHIFT for y < 2**14
  localparam logic [12:0] RECIP_100  = 13'd5243;
  localparam int          Q100_SHIFT = 19;
  // floor(yy / 400) = (yy * RECIP_400) >> Q400_SHIFT for yy < 2**15
  localparam logic [13:0] RECIP_400  = 14'd10486;
  localparam int          Q400_SHIFT = 22;

  localparam logic [17:0]      DAYS_PER_ERA = 18'd146097;
  localparam logic [GAP_W-1:0] GAP_MAX      = 22'd3652424;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_FIRST_BAD  = 2'd1,
    STATUS_SECOND_BAD = 2'd2
  } status_t;

  // Per-stage load enables for the date pipeline.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_adv_t;

  // Days in a month; zero for a month code outside 1..12.
  function automatic logic [4:0] month_len(input logic [MD_W-1:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                   len = 5'd30;
      7'd2:                                      len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

  // Days from March 1 to the first of the month (year starts in March).
  function automatic logic [8:0] march_offset(input logic [MD_W-1:0] m);
    logic [8:0] ofs;
    unique case (m)
      7'd3:    ofs = 9'd0;
      7'd4:    ofs = 9'd31;
      7'd5:    ofs = 9'd61;
      7'd6:    ofs = 9'd92;
      7'd7:    ofs = 9'd122;
      7'd8:    ofs = 9'd153;
      7'd9:    ofs = 9'd184;
      7'd10:   ofs = 9'd214;
      7'd11:   ofs = 9'd245;
      7'd12:   ofs = 9'd275;
      7'd1:    ofs = 9'd306;
      7'd2:    ofs = 9'd337;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage

// File: rtl/civdg_date.sv
// Four-stage pipeline: validates one date and converts it to a serial day count.
// Depends on civdg_pkg; stage enables come from the top level's valid/ready chain.
module civdg_date import civdg_pkg::*; (
  input  logic              clk,
  input  pipe_adv_t         adv,
  input  logic [YEAR_W-1:0] year,
  input  logic [MD_W-1:0]   month,
  input  logic [MD_W-1:0]   day,
  output logic              date_ok,
  output logic [GAP_W-1:0]  serial
);

  // stage 1: century quotient, March-based year
  logic [26:0]       prod100;
  logic [7:0]        q100_nxt;
  logic [14:0]       yy_nxt;
  logic [YEAR_W-1:0] y1_r;
  logic [MD_W-1:0]   m1_r;
  logic [MD_W-1:0]   d1_r;
  logic [7:0]        q1_r;
  logic [14:0]       yy1_r;

  always_comb begin
    prod100  = 27'(year) * 27'(RECIP_100);
    q100_nxt = 8'(prod100 >> Q100_SHIFT);
    yy_nxt   = 15'(year) + YEAR_SHIFT - ((month <= 7'd2) ? 15'd1 : 15'd0);
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      y1_r  <= year;
      m1_r  <= month;
      d1_r  <= day;
      q1_r  <= q100_nxt;
      yy1_r <= yy_nxt;
    end
  end

  // stage 2: leap rule, range check, era, day of year
  logic        leap;
  logic [13:0] cent_yr;
  logic        ok_nxt;
  logic [28:0] prod400;
  logic [5:0]  era_nxt;
  logic [8:0]  doy_nxt;
  logic        ok2_r;
  logic [5:0]  era2_r;
  logic [14:0] yy2_r;
  logic [8:0]  doy2_r;

  always_comb begin
    cent_yr = 14'(14'(q1_r) * 14'd100);
    // divisible by 400 == divisible by 100 and quotient divisible by 4
    leap    = (y1_r[1:0] == 2'b00) && ((y1_r != cent_yr) || (q1_r[1:0] == 2'b00));
    ok_nxt  = (y1_r <= YEAR_MAX) && (d1_r != 7'd0) &&
              (d1_r <= 7'(month_len(m1_r, leap)));
    prod400 = 29'(yy1_r) * 29'(RECIP_400);
    era_nxt = 6'(prod400 >> Q400_SHIFT);
    doy_nxt = march_offset(m1_r) + 9'(d1_r) - 9'd1;
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      ok2_r  <= ok_nxt;
      era2_r <= era_nxt;
      yy2_r  <= yy1_r;
      doy2_r <= doy_nxt;
    end
  end

  // stage 3: year of era
  logic [14:0] era_yrs;
  logic [8:0]  yoe_nxt;
  logic        ok3_r;
  logic [5:0]  era3_r;
  logic [8:0]  yoe3_r;
  logic [8:0]  doy3_r;

  always_comb begin
    era_yrs = 15'(15'(era2_r) * 15'd400);
    yoe_nxt = 9'(yy2_r - era_yrs);
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      ok3_r  <= ok2_r;
      era3_r <= era2_r;
      yoe3_r <= yoe_nxt;
      doy3_r <= doy2_r;
    end
  end

  // stage 4: day of era plus whole eras
  logic [1:0]       c100;
  logic [17:0]      doe;
  logic [23:0]      era_days;
  logic [GAP_W-1:0] serial_nxt;
  logic             ok4_r;
  logic [GAP_W-1:0] serial4_r;

  always_comb begin
    if (yoe3_r >= 9'd300)      c100 = 2'd3;
    else if (yoe3_r >= 9'd200) c100 = 2'd2;
    else if (yoe3_r >= 9'd100) c100 = 2'd1;
    else                       c100 = 2'd0;
    doe        = 18'(yoe3_r) * 18'd365 + 18'(yoe3_r >> 2) - 18'(c100) + 18'(doy3_r);
    era_days   = 24'(era3_r) * 24'(DAYS_PER_ERA);
    serial_nxt = GAP_W'(era_days + 24'(doe));
  end

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      ok4_r     <= ok3_r;
      serial4_r <= serial_nxt;
    end
  end

  assign date_ok = ok4_r;
  assign serial  = serial4_r;

endmodule

// File: rtl/civil_date_day_gap_top.sv
// A request accepted on in_ready passes the four date stages, then the registered
// gap/status stage, before it shows on out_valid.
// Throughput: one request per cycle unless stalled; a stall holds only full
// stages; bubbles are squeezed out, so input keeps flowing while a result waits.
// Reset: synchronous, active-low rst_n clears all valid bits; payload is not reset.
// Depends on civdg_pkg and civdg_date.
module civil_date_day_gap_top import civdg_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [YEAR_W-1:0]   in_first_year,
  input  logic [MD_W-1:0]     in_first_month,
  input  logic [MD_W-1:0]     in_first_day,
  input  logic [YEAR_W-1:0]   in_second_year,
  input  logic [MD_W-1:0]     in_second_month,
  input  logic [MD_W-1:0]     in_second_day,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [GAP_W-1:0]    out_day_gap,
  output logic [STATUS_W-1:0] out_status
);

  logic [4:1] v_r;
  logic [4:1] rdy;
  logic       rdy_out;
  pipe_adv_t  adv;

  logic                out_valid_r;
  logic [GAP_W-1:0]    out_day_gap_r;
  status_t             out_status_r;

  // a stage may load when empty or when its contents move on
  always_comb begin
    rdy_out = !out_valid_r || out_ready;
    rdy[4]  = !v_r[4] || rdy_out;
    rdy[3]  = !v_r[3] || rdy[4];
    rdy[2]  = !v_r[2] || rdy[3];
    rdy[1]  = !v_r[1] || rdy[2];
    adv.s1  = rdy[1];
    adv.s2  = rdy[2];
    adv.s3  = rdy[3];
    adv.s4  = rdy[4];
  end

  assign in_ready = rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy[1])  v_r[1]      <= in_valid;
      if (rdy[2])  v_r[2]      <= v_r[1];
      if (rdy[3])  v_r[3]      <= v_r[2];
      if (rdy[4])  v_r[4]      <= v_r[3];
      if (rdy_out) out_valid_r <= v_r[4];
    end
  end

  logic             ok_a;
  logic             ok_b;
  logic [GAP_W-1:0] serial_a;
  logic [GAP_W-1:0] serial_b;

  civdg_date u_date_a (
    .clk     (clk),
    .adv     (adv),
    .year    (in_first_year),
    .month   (in_first_month),
    .day     (in_first_day),
    .date_ok (ok_a),
    .serial  (serial_a)
  );

  civdg_date u_date_b (
    .clk     (clk),
    .adv     (adv),
    .year    (in_second_year),
    .month   (in_second_month),
    .day     (in_second_day),
    .date_ok (ok_b),
    .serial  (serial_b)
  );

  // output stage: error priority and absolute difference
  status_t          status_nxt;
  logic [GAP_W-1:0] gap_nxt;

  always_comb begin
    if (!ok_a) begin
      status_nxt = STATUS_FIRST_BAD;
      gap_nxt    = '0;
    end else if (!ok_b) begin
      status_nxt = STATUS_SECOND_BAD;
      gap_nxt    = '0;
    end else begin
      status_nxt = STATUS_OK;
      gap_nxt    = (serial_a >= serial_b) ? (serial_a - serial_b) : (serial_b - serial_a);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && v_r[4]) begin
      out_day_gap_r <= gap_nxt;
      out_status_r  <= status_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_day_gap = out_day_gap_r;
  assign out_status  = out_status_r;

  // errored requests carry a zero gap
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r == STATUS_OK) || (out_day_gap_r == '0))
    else $error("nonzero gap on an errored request");

  // gap of two valid dates stays in range
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STATUS_OK) |-> (out_day_gap_r <= GAP_MAX))
    else $error("day gap out of range");

  // last date stage holds its request and data while the output stage is blocked
  assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[4] && !rdy[4]) |=> (v_r[4] && $stable(serial_a) && $stable(serial_b) &&
                             $stable(ok_a) && $stable(ok_b)))
    else $error("stalled request lost in date pipeline");

endmodule
